FILE: rtl/core/beast_binary_frame_encoder_assert.svh
// Assertion macros for the back part of the frame encoder.
`ifndef BEAST_BINARY_FRAME_ENCODER_ASSERT_SVH
`define BEAST_BINARY_FRAME_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBFE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frame encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frame encoder check failed");

`endif

FILE: rtl/core/bbfe_pkg.sv
// Package with the types and constants of the binary frame encoder.
package bbfe_pkg;

    localparam int unsigned TS_W = 48;
    localparam int unsigned LEN_W = 4;
    localparam int unsigned IDX_W = 4;

    localparam logic [7:0] ESC_BYTE = 8'h1A;
    localparam logic [7:0] TYPE_MODEAC = 8'h31;
    localparam logic [7:0] TYPE_SHORT = 8'h32;
    localparam logic [7:0] TYPE_LONG = 8'h33;

    localparam logic [LEN_W-1:0] LEN_MODEAC = 4'd2;
    localparam logic [LEN_W-1:0] LEN_SHORT = 4'd7;
    localparam logic [LEN_W-1:0] MAX_MSG_BYTES = 4'd14;

    localparam logic [TS_W-1:0] MODEAC_TIME_SKEW = TS_W'(377 * 20);

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Byte positions within one queued word.
    localparam logic [IDX_W-1:0] IDX_ESC = 4'd0;
    localparam logic [IDX_W-1:0] IDX_TYPE = 4'd1;
    localparam logic [IDX_W-1:0] IDX_TS_LAST = 4'd7;
    localparam logic [IDX_W-1:0] IDX_TAIL = 4'd8;

    typedef struct packed {
        logic            is_hdr;
        logic [7:0]      type_byte;
        logic [TS_W-1:0] ts;
        logic [7:0]      tail_byte;
        logic            frame_last;
    } t_job;

endpackage

FILE: rtl/core/bbfe_front.sv
// Front part: accepts input words, checks lengths and builds jobs for the queue.
module bbfe_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_opcode,
    input  logic [bbfe_pkg::TS_W-1:0]  i_timestamp,
    input  logic [7:0]                 i_signal_level,
    input  logic [bbfe_pkg::LEN_W-1:0] i_length_bytes,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_q_full,
    output logic                       o_q_wr,
    output bbfe_pkg::t_job             o_q_data
);
    import bbfe_pkg::*;

    logic [LEN_W-1:0] r_remaining;
    logic [LEN_W-1:0] n_remaining;
    logic             accept;
    logic             is_hdr;
    logic             len_ok;
    logic [7:0]       type_byte;
    logic [TS_W-1:0]  ts_adj;

    assign accept = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign is_hdr = (i_opcode == OP_HEADER);

    always_comb begin
        len_ok = 1'b1;
        type_byte = TYPE_LONG;
        ts_adj = i_timestamp;
        case (i_length_bytes)
            LEN_SHORT: begin
                type_byte = TYPE_SHORT;
            end
            MAX_MSG_BYTES: begin
                type_byte = TYPE_LONG;
            end
            LEN_MODEAC: begin
                type_byte = TYPE_MODEAC;
                ts_adj = i_timestamp + MODEAC_TIME_SKEW;
            end
            default: begin
                len_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_q_data.is_hdr = is_hdr;
        o_q_data.type_byte = type_byte;
        o_q_data.ts = ts_adj;
        o_q_data.tail_byte = is_hdr ? i_signal_level : i_data_byte;
        o_q_data.frame_last = !is_hdr && (r_remaining == LEN_W'(1));
        o_q_wr = accept && (is_hdr ? len_ok : (r_remaining != '0));
    end

    always_comb begin
        n_remaining = r_remaining;
        if (accept) begin
            if (is_hdr) begin
                n_remaining = len_ok ? i_length_bytes : '0;
            end else if (r_remaining != '0) begin
                n_remaining = r_remaining - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
        end else begin
            r_remaining <= n_remaining;
        end
    end

endmodule

FILE: rtl/core/bbfe_queue.sv
// Short job queue between the front and back parts.
module bbfe_queue #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  bbfe_pkg::t_job i_wr_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_rd_valid,
    output bbfe_pkg::t_job o_rd_data
);
    import bbfe_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr = i_wr && !o_full;
    assign do_rd = i_rd && o_rd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/core/bbfe_back.sv
// Back part: serializes queued jobs into escaped bytes behind an output register.
module bbfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  bbfe_pkg::t_job i_q_data,
    output logic           o_q_rd,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_frame_end
);
    import bbfe_pkg::*;

    `include "beast_binary_frame_encoder_assert.svh"

    t_job             r_job;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_dup;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_fend;
    t_job             n_job;
    logic             n_busy;
    logic [IDX_W-1:0] n_idx;
    logic             n_dup;
    logic             n_out_valid;
    logic [7:0]       n_out_byte;
    logic             n_out_last;
    logic             n_out_fend;
    logic             adv;
    logic             emit;
    logic             need_dup;
    logic             byte_last;
    logic             item_done;
    logic             pop;
    logic [2:0]       ts_sel;
    logic [7:0]       cur_byte;

    assign ts_sel = 3'(IDX_TS_LAST - r_idx);

    always_comb begin
        case (r_idx)
            IDX_ESC: cur_byte = ESC_BYTE;
            IDX_TYPE: cur_byte = r_job.type_byte;
            IDX_TAIL: cur_byte = r_job.tail_byte;
            default: cur_byte = r_job.ts[{ts_sel, 3'b000} +: 8];
        endcase
    end

    assign adv = !r_out_valid || !i_out_stall;
    assign emit = r_busy && adv;
    assign need_dup = (cur_byte == ESC_BYTE) && (r_idx != IDX_ESC) && !r_dup;
    assign byte_last = !need_dup && (r_idx == IDX_TAIL);
    assign item_done = emit && byte_last;
    assign pop = i_q_valid && (!r_busy || item_done);
    assign o_q_rd = pop;

    always_comb begin
        n_job = r_job;
        n_busy = r_busy;
        n_idx = r_idx;
        n_dup = r_dup;
        n_out_valid = r_out_valid;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        n_out_fend = r_out_fend;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte = cur_byte;
            n_out_last = byte_last;
            n_out_fend = byte_last && r_job.frame_last;
            n_dup = need_dup;
            if (!need_dup && !byte_last) begin
                n_idx = r_idx + IDX_W'(1);
            end
        end else if (adv) begin
            n_out_valid = 1'b0;
        end
        if (pop) begin
            n_job = i_q_data;
            n_busy = 1'b1;
            n_idx = i_q_data.is_hdr ? IDX_ESC : IDX_TAIL;
            n_dup = 1'b0;
        end else if (item_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_fend <= n_out_fend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= IDX_ESC;
            r_dup <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx <= n_idx;
            r_dup <= n_dup;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_out_last;
    assign o_frame_end = r_out_fend;

    `BBFE_ASSERT_SAME(a_fend_is_last, i_clk, i_rst_n, r_out_valid && r_out_fend, r_out_last)
    `BBFE_ASSERT_SAME(a_dup_follows_esc, i_clk, i_rst_n, r_busy && r_dup, r_out_valid && (r_out_byte == ESC_BYTE))
    `BBFE_ASSERT_NEXT(a_pop_loads_job, i_clk, i_rst_n, pop, r_busy && !r_dup)

endmodule

FILE: rtl/core/beast_binary_frame_encoder.sv
// Top level of the Mode A/C/S binary frame encoder with escape stuffing.
//
//   Channel   Direction   Handshake                  Fields
//   in        to block    i_in_valid / o_in_stall    opcode, timestamp, level, length, data
//   out       from block  o_out_valid / i_out_stall  out_byte, run_last, frame_end
//
// Unless the output stalls, the back part emits one byte per cycle from its output register.
// A header word becomes 9 to 16 output bytes and a payload word 1 or 2, set by escape doubling.
// The front accepts a word per cycle while the job queue has room.
// Reset is synchronous and active low and closes any open message.
// An output stall holds the output register and fills the queue before the input stalls.
module beast_binary_frame_encoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_opcode,
    input  logic [bbfe_pkg::TS_W-1:0]  i_timestamp,
    input  logic [7:0]                 i_signal_level,
    input  logic [bbfe_pkg::LEN_W-1:0] i_length_bytes,
    input  logic [7:0]                 i_data_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_run_last,
    output logic                       o_frame_end
);
    import bbfe_pkg::*;

    logic q_full;
    logic q_wr;
    t_job q_wr_data;
    logic q_rd;
    logic q_valid;
    t_job q_rd_data;

    bbfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_timestamp    (i_timestamp),
        .i_signal_level (i_signal_level),
        .i_length_bytes (i_length_bytes),
        .i_data_byte    (i_data_byte),
        .i_q_full       (q_full),
        .o_q_wr         (q_wr),
        .o_q_data       (q_wr_data)
    );

    bbfe_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .i_wr_data  (q_wr_data),
        .o_full     (q_full),
        .i_rd       (q_rd),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_rd_data)
    );

    bbfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rd_data),
        .o_q_rd      (q_rd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

endmodule
